@@ rtl/bsbd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the bass slope beat detector.
// No dependencies; every other file of the block imports this package.
package bsbd_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    CFG_MIN_BEAT_GAP      = 2'd0,
    CFG_PHASE_WINDOW      = 2'd1,
    CFG_CONFIDENCE_STEP   = 2'd2,
    CFG_PREDICT_THRESHOLD = 2'd3
  } cfg_idx_t;

  localparam int CfgDataW = 17;

  // Register reset values.
  localparam logic [15:0] MinBeatGapRst      = 16'd21845;
  localparam logic [15:0] PhaseWindowRst     = 16'd13107;
  localparam logic [15:0] ConfidenceStepRst  = 16'd6226;
  localparam logic [16:0] PredictThresholdRst = 17'd59638;

  // State reset values.
  localparam logic [23:0] SlopeMin   = 24'd201327;  // 0.012 in Q0.24
  localparam logic [23:0] SlopeMax   = 24'd335544;  // 0.02 in Q0.24
  localparam logic [16:0] ConfMin    = 17'd32768;   // 0.5 in Q1.16
  localparam logic [16:0] ConfMax    = 17'd65536;   // 1.0 in Q1.16
  localparam logic [16:0] ConfRst    = 17'd39322;   // 0.6 in Q1.16
  localparam logic [31:0] PeriodRst  = 32'd2621440; // 40.0 in Q16.16

  // Multipliers below one are applied as x - ceil(x * (65536 - k) / 65536),
  // which equals (x * k) >> 16 for non-negative x.
  localparam logic [4:0]  ConfDecayLoss = 5'd26;    // 65536 - 65510
  localparam logic [11:0] PredictLoss   = 12'd3277; // 65536 - 62259
  localparam logic [6:0]  PeakDecayLoss = 7'd66;    // 65536 - 65470

  // Slope = level difference * 256 / 30 = d * 128 / 15. For d * 128 below
  // 2^23 the quotient by 15 is exact as (x * RecipFifteen) >> 31.
  localparam logic [27:0] RecipFifteen = 28'd143165577;
  localparam logic [15:0] SlopeDiffMax = 16'hFFFF;

  typedef struct packed {
    logic [15:0] min_beat_gap;
    logic [15:0] phase_window;
    logic [15:0] confidence_step;
    logic [16:0] predict_threshold;
  } cfg_t;

  typedef struct packed {
    logic [31:0] frame_time;
    logic [23:0] bass_level;
  } item_t;

  typedef struct packed {
    logic [23:0] prev_bass;
    logic [23:0] peak_slope;
    logic [16:0] confidence;
    logic [31:0] beat_time;
    logic [31:0] beat_period;
  } state_t;

  typedef struct packed {
    logic        beat_flag;
    logic [31:0] last_beat_time;
    logic [31:0] beat_interval;
    logic [16:0] confidence;
  } result_t;

  // Clamp an 18-bit confidence candidate into [ConfMin, ConfMax].
  function automatic logic [16:0] clamp_conf(input logic [17:0] v);
    logic [16:0] r;
    if (v < {1'b0, ConfMin}) begin
      r = ConfMin;
    end else if (v > {1'b0, ConfMax}) begin
      r = ConfMax;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/bsbd_cfg.sv @@
`timescale 1ns / 1ps
// Configuration registers of the beat detector, written through a plain
// write port. Depends on bsbd_pkg.
module bsbd_cfg
  import bsbd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                wen,
  input  logic [1:0]          addr,
  input  logic [CfgDataW-1:0] wdata,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_beat_gap      <= MinBeatGapRst;
      cfg.phase_window      <= PhaseWindowRst;
      cfg.confidence_step   <= ConfidenceStepRst;
      cfg.predict_threshold <= PredictThresholdRst;
    end else if (wen) begin
      unique case (cfg_idx_t'(addr))
        CFG_MIN_BEAT_GAP:      cfg.min_beat_gap      <= wdata[15:0];
        CFG_PHASE_WINDOW:      cfg.phase_window      <= wdata[15:0];
        CFG_CONFIDENCE_STEP:   cfg.confidence_step   <= wdata[15:0];
        CFG_PREDICT_THRESHOLD: cfg.predict_threshold <= wdata;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/bsbd_calc.sv @@
`timescale 1ns / 1ps
// Per-frame update of the beat detector: slope, peak, confidence and beat
// decision, all combinational from the current state. Depends on bsbd_pkg.
module bsbd_calc
  import bsbd_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  st,
  input  item_t   item,
  output state_t  st_next,
  output result_t res
);

  logic signed [24:0] diff;
  logic [15:0]        diff_clip;
  logic [22:0]        slope_num;
  logic [50:0]        slope_prod;
  logic [19:0]        slope;
  logic [22:0]        slope_x5;
  logic [25:0]        peak_x3;
  logic [29:0]        peak_loss;
  logic [23:0]        peak_dec;
  logic [23:0]        peak_max;
  logic signed [33:0] gap;
  logic [32:0]        expected;
  logic signed [33:0] off_s;
  logic [33:0]        off;
  logic               hit_det;
  logic               in_phase;
  logic [22:0]        decay_loss;
  logic [17:0]        conf_up;
  logic [16:0]        conf_upd;
  logic [28:0]        pred_loss;
  logic               forced;
  logic               hit;
  logic [16:0]        conf_fin;

  always_comb begin
    // Slope only matters between zero and a little past SlopeMax, so the
    // difference is clipped to 16 bits before the reciprocal multiply.
    diff = $signed({1'b0, item.bass_level}) - $signed({1'b0, st.prev_bass});
    if (diff < 0) begin
      diff_clip = '0;
    end else if (diff > $signed({9'd0, SlopeDiffMax})) begin
      diff_clip = SlopeDiffMax;
    end else begin
      diff_clip = diff[15:0];
    end
    slope_num  = {diff_clip, 7'd0};
    slope_prod = 51'(slope_num) * 51'(RecipFifteen);
    slope      = slope_prod[50:31];

    // 0.6 threshold test done exactly as 5 * slope > 3 * peak.
    slope_x5 = 23'(slope) * 23'd5;
    peak_x3  = 26'(st.peak_slope) * 26'd3;

    gap     = $signed({2'b0, item.frame_time}) - $signed({2'b0, st.beat_time});
    hit_det = (26'(slope_x5) > peak_x3) && (gap > $signed({18'd0, cfg.min_beat_gap}));

    expected = 33'(st.beat_time) + 33'(st.beat_period);
    off_s    = $signed({2'b0, item.frame_time}) - $signed({1'b0, expected});
    off      = (off_s < 0) ? 34'(-off_s) : 34'(off_s);
    in_phase = off < 34'(cfg.phase_window);

    // Confidence: step up in phase, step down off phase, else slow decay.
    decay_loss = 23'(st.confidence) * 23'(ConfDecayLoss) + 23'd65535;
    conf_up    = 18'(st.confidence) + 18'(cfg.confidence_step);
    priority if (hit_det && in_phase) begin
      conf_upd = clamp_conf(conf_up);
    end else if (hit_det) begin
      if (18'(st.confidence) < 18'(cfg.confidence_step) + 18'(ConfMin)) begin
        conf_upd = ConfMin;
      end else begin
        conf_upd = st.confidence - 17'(cfg.confidence_step);
      end
    end else begin
      conf_upd = clamp_conf(18'(st.confidence - 17'(decay_loss[22:16])));
    end

    // Predicted beat: expected time passed with high confidence.
    forced    = ({1'b0, item.frame_time} > expected) &&
                (conf_upd > cfg.predict_threshold);
    pred_loss = 29'(conf_upd) * 29'(PredictLoss) + 29'd65535;
    conf_fin  = forced ? (conf_upd - 17'(pred_loss[28:16])) : conf_upd;
    hit       = hit_det || forced;

    // Peak slope decays by 0.999 per frame, follows a larger slope.
    peak_loss = 30'(st.peak_slope) * 30'(PeakDecayLoss) + 30'd65535;
    peak_dec  = st.peak_slope - 24'(peak_loss[29:16]);
    peak_max  = (24'(slope) > peak_dec) ? 24'(slope) : peak_dec;

    st_next.prev_bass  = item.bass_level;
    st_next.confidence = conf_fin;
    if (peak_max < SlopeMin) begin
      st_next.peak_slope = SlopeMin;
    end else if (peak_max > SlopeMax) begin
      st_next.peak_slope = SlopeMax;
    end else begin
      st_next.peak_slope = peak_max;
    end
    if (hit) begin
      st_next.beat_time   = item.frame_time;
      st_next.beat_period = (gap < 0) ? '0 : gap[31:0];
    end else begin
      st_next.beat_time   = st.beat_time;
      st_next.beat_period = st.beat_period;
    end

    res.beat_flag      = hit;
    res.last_beat_time = st_next.beat_time;
    res.beat_interval  = st_next.beat_period;
    res.confidence     = conf_fin;
  end

endmodule

@@ rtl/bass_slope_beat_detector.sv @@
`timescale 1ns / 1ps
// Top level of the bass slope beat detector: input register, state and
// result register around bsbd_calc and bsbd_cfg. Depends on bsbd_pkg.
//
// Usage:
// Each input beat on the s_ stream carries one video frame: its time stamp
// (Q16.16 seconds, non-decreasing) and its bass energy (Q8.16). For every
// input beat exactly one result beat leaves on the m_ stream with the beat
// flag, the time of the latest beat, the interval between the last two
// beats and the phase confidence, all as they stand after that frame.
// The block holds one frame in its input register; the whole update is
// combinational from that register into the state and the result register,
// so a result is offered from the result register once its frame has left the
// input register, and a new frame can be taken every cycle while m_tready is high.
// When the receiver stalls, the result register holds its beat and the
// input register can still take one more frame; s_tready drops only when
// both are full and m_tready is low.
// The configuration port writes one register per cycle with cfg_wen; it is
// meant to be written while no frame is in flight.
// Reset (rst, synchronous) empties both registers and returns the
// configuration and all detector state to their default values.
module bass_slope_beat_detector
  import bsbd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Input stream.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [55:0]         s_tdata,  // frame_time[31:0], bass_level[55:32]
  // Result stream.
  output logic                m_tvalid,
  input  logic                m_tready,
  // beat_flag[0], last_beat_time[32:1], beat_interval[64:33],
  // confidence[81:65], zero padding[87:82]
  output logic [87:0]         m_tdata,
  // Configuration write port.
  input  logic                cfg_wen,
  input  logic [1:0]          cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  item_t   in_item;
  logic    in_valid;
  result_t res;
  result_t res_next;
  logic    advance;

  bsbd_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wen   (cfg_wen),
    .addr  (cfg_addr),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  bsbd_calc u_calc (
    .cfg     (cfg),
    .st      (st),
    .item    (in_item),
    .st_next (st_next),
    .res     (res_next)
  );

  // The held frame moves on whenever the result register is free or drains.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.frame_time <= s_tdata[31:0];
      in_item.bass_level <= s_tdata[55:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.prev_bass   <= '0;
      st.peak_slope  <= SlopeMin;
      st.confidence  <= ConfRst;
      st.beat_time   <= '0;
      st.beat_period <= PeriodRst;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {6'd0, res.confidence, res.beat_interval, res.last_beat_time,
                    res.beat_flag};

  // The peak slope never leaves its clamp range.
  a_peak_range: assert property (@(posedge clk) disable iff (rst)
    (st.peak_slope >= SlopeMin) && (st.peak_slope <= SlopeMax))
    else $error("peak slope outside its range");

  // A frame without a beat leaves the beat time and interval untouched.
  a_no_beat_hold: assert property (@(posedge clk) disable iff (rst)
    advance && !res_next.beat_flag |=> $stable(st.beat_time) && $stable(st.beat_period))
    else $error("beat state changed on a frame without a beat");

  // Back pressure comes only from a full input register and a stalled result.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without a downstream stall");

  // A result reports the beat time and interval that the state now holds.
  a_result_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> (res.last_beat_time == st.beat_time) &&
                (res.beat_interval == st.beat_period))
    else $error("result disagrees with detector state");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for bass_slope_beat_detector: a predictor class
// tracks slope peak, phase confidence and beat timing and checks every result.
// Depends on bsbd_pkg and the RTL of the block; reads no files.
module tb;
  import bsbd_pkg::*;

  // Fixed-point constants of the detector, kept as signed 64-bit values so that
  // every comparison in the predictor is a signed one.
  localparam longint FrameRate   = 30;
  localparam longint ConfDecayK  = 65510;   // 0.9996 in Q0.16
  localparam longint PredictK    = 62259;   // 0.95 in Q0.16
  localparam longint PeakDecayK  = 65470;   // 0.999 in Q0.16
  localparam longint SlopeLo     = 201327;  // 0.012 in Q0.24
  localparam longint SlopeHi     = 335544;  // 0.02 in Q0.24
  localparam longint ConfLo      = 32768;   // 0.5 in Q1.16
  localparam longint ConfHi      = 65536;   // 1.0 in Q1.16
  localparam longint SpanHi      = 64'sh0000_0000_FFFF_FFFF;

  localparam int FrameStep    = 2185;  // 1/30 s in Q16.16
  localparam int PhaseCount   = 8;
  localparam int PhaseFrames  = 62;
  localparam int LongHold     = 150;   // receiver hold-off that fills the block
  localparam int QuietLimit   = 2000;  // cycles without any accepted beat
  localparam int TailCycles   = 8;

  // Predictor and checker. note_frame() advances a private copy of the
  // detector state for each accepted input beat and queues the result it
  // should produce; check_result() compares each output beat with the oldest
  // queued result.
  class beat_checker;
    logic [15:0] min_gap;
    logic [15:0] window;
    logic [15:0] conf_step;
    logic [16:0] threshold;

    logic [23:0] prev_bass;
    logic [23:0] peak_slope;
    logic [16:0] conf;
    logic [31:0] beat_time;
    logic [31:0] beat_period;

    result_t pending_reports[$];
    int n_frames;
    int n_results;
    int n_hits;
    int n_forced;
    int n_in_phase;
    int n_errors;

    function new();
      min_gap     = MinBeatGapRst;
      window      = PhaseWindowRst;
      conf_step   = ConfidenceStepRst;
      threshold   = PredictThresholdRst;
      prev_bass   = '0;
      peak_slope  = SlopeMin;
      conf        = ConfRst;
      beat_time   = '0;
      beat_period = PeriodRst;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [16:0] v);
      case (idx)
        CFG_MIN_BEAT_GAP:      min_gap   = v[15:0];
        CFG_PHASE_WINDOW:      window    = v[15:0];
        CFG_CONFIDENCE_STEP:   conf_step = v[15:0];
        CFG_PREDICT_THRESHOLD: threshold = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function void note_frame(logic [31:0] t, logic [23:0] lvl);
      longint now, level, prev, last, period, expected, slope, pk, c, off, span;
      longint gap, win, stp, thr;
      bit hit, forced;
      result_t r;
      // Widen everything to signed 64 bits first; mixing in an unsigned
      // vector would turn the slope arithmetic unsigned.
      now = t;
      level = lvl;
      prev = prev_bass;
      last = beat_time;
      period = beat_period;
      pk = peak_slope;
      c = conf;
      gap = min_gap;
      win = window;
      stp = conf_step;
      thr = threshold;
      expected = last + period;

      // Slope per frame in Q0.24, truncated toward zero; the 0.6 test is exact.
      slope = ((level - prev) * 256) / FrameRate;
      hit = (5 * slope > 3 * pk) && (now - last > gap);

      off = now - expected;
      if (off < 0) off = -off;
      if (hit && off < win) begin
        c = c + stp;
        n_in_phase++;
      end else if (hit) begin
        c = c - stp;
      end else begin
        c = (c * ConfDecayK) >>> 16;
      end
      if (c < ConfLo) c = ConfLo;
      else if (c > ConfHi) c = ConfHi;

      // A missed beat is forced once confidence is high and its time is past.
      forced = (now > expected) && (c > thr);
      if (forced) begin
        hit = 1'b1;
        c = (c * PredictK) >>> 16;
        n_forced++;
      end
      conf = c[16:0];

      pk = (pk * PeakDecayK) >>> 16;
      if (slope > pk) pk = slope;
      if (pk < SlopeLo) pk = SlopeLo;
      else if (pk > SlopeHi) pk = SlopeHi;
      peak_slope = pk[23:0];

      if (hit) begin
        span = now - last;
        if (span < 0) span = 0;
        else if (span > SpanHi) span = SpanHi;
        beat_period = span[31:0];
        beat_time = t;
        n_hits++;
      end
      prev_bass = lvl;

      r.beat_flag      = hit;
      r.last_beat_time = beat_time;
      r.beat_interval  = beat_period;
      r.confidence     = conf;
      pending_reports.push_back(r);
      n_frames++;
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(logic [87:0] d);
      result_t e;
      if (pending_reports.size() == 0) begin
        $error("result beat with no frame outstanding: %h", d);
        n_errors++;
        return;
      end
      e = pending_reports.pop_front();
      n_results++;
      compare_field("beat_flag", 32'(e.beat_flag), 32'(d[0]));
      compare_field("last_beat_time", e.last_beat_time, d[32:1]);
      compare_field("beat_interval", e.beat_interval, d[64:33]);
      compare_field("confidence", 32'(e.confidence), 32'(d[81:65]));
      compare_field("padding", 32'd0, 32'(d[87:82]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // frame_time[31:0], bass_level[55:32]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;        // beat_flag[0], last_beat_time[32:1],
                               // beat_interval[64:33], confidence[81:65]
  logic                cfg_wen = 1'b0;
  logic [1:0]          cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  beat_checker chk = new();

  // Idle percentages for the current phase, and the request for one long
  // receiver hold-off. The receiver process counts the hold-off itself.
  int idle_pct = 0;
  int stall_pct = 0;
  bit long_hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  bass_slope_beat_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: check every accepted result beat, then decide tready for the
  // next edge. Values are sampled at the edge before any update lands.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      chk.check_result(m_tdata);
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      m_tready <= 1'b0;
      hold_left <= LongHold;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: a long run of cycles with no accepted beat on either stream
  // and no register write means the block has hung.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: nothing accepted for %0d cycles, %0d results outstanding",
               quiet_cycles, chk.pending());
      $display("tb NOT OK");
      $finish;
    end
  end

  // Offer one frame, with random idle cycles ahead of it, and hand it to the
  // predictor at the edge where it is accepted. tvalid stays high when the
  // next frame follows without a gap.
  task automatic send_frame(input logic [31:0] t, input logic [23:0] lvl);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {lvl, t};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chk.note_frame(t, lvl);
  endtask

  // Stop offering frames until every outstanding result has been taken.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [16:0] v);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    chk.set_reg(idx, v);
  endtask

  // Writes all four registers back to back; only called with the block idle.
  task automatic write_config(input logic [15:0] gap, input logic [15:0] win,
                              input logic [15:0] stp, input logic [16:0] thr);
    put_reg(CFG_MIN_BEAT_GAP, {1'b0, gap});
    put_reg(CFG_PHASE_WINDOW, {1'b0, win});
    put_reg(CFG_CONFIDENCE_STEP, {1'b0, stp});
    put_reg(CFG_PREDICT_THRESHOLD, thr);
    cfg_wen <= 1'b0;
  endtask

  // Directed frames: level and time extremes, a hit that is off phase, a zero
  // and a negative time gap, then settings where prediction fires at once and
  // where it can never fire, ending at the top of the time range.
  task automatic run_directed();
    send_frame(32'd0, 24'd0);
    send_frame(32'd2185, 24'hFF_FFFF);
    send_frame(32'd4370, 24'd0);
    send_frame(32'd30000, 24'h40_0000);
    send_frame(32'd30000, 24'h80_0000);
    send_frame(32'd20000, 24'hC0_0000);
    send_frame(32'd65536, 24'd0);
    send_frame(32'd98304, 24'h80_0000);
    wait_idle();

    // Zero gap, widest window, largest step, lowest threshold.
    write_config(16'd0, 16'hFFFF, 16'd32768, 17'd32768);
    for (int k = 0; k < 8; k++) begin
      send_frame(32'd131072 + 32'(k) * 32'd8000, (k % 2 == 1) ? 24'h30_0000 : 24'd0);
    end
    wait_idle();

    // Widest gap, zero window and step, a threshold no confidence exceeds.
    write_config(16'hFFFF, 16'd0, 16'd0, 17'd65536);
    send_frame(32'h0010_0000, 24'h01_0000);
    send_frame(32'h0020_0000, 24'h90_0000);
    send_frame(32'hFFFF_0000, 24'd0);
    send_frame(32'hFFFF_FFFF, 24'hFF_FFFF);
    send_frame(32'hFFFF_FFFF, 24'd0);
    wait_idle();
  endtask

  // A stretch of music: a steady floor with small noise and a bass pulse every
  // few frames, some pulses dropped so that prediction gets its chance. Times
  // advance by about one frame, now and then repeating or stepping back.
  task automatic play_song(input int frames);
    int period, floor_lvl, noise_max, pulse_amp, drop_pct, r;
    logic [31:0] t;
    logic [23:0] lvl;
    period    = $urandom_range(6, 24);
    floor_lvl = $urandom_range(0, 24'hB0_0000);
    noise_max = $urandom_range(0, 16'h3000);
    pulse_amp = $urandom_range(16'h3000, 24'h40_0000);
    drop_pct  = $urandom_range(0, 30);
    t = $urandom_range(0, 32'hF000_0000);
    for (int i = 0; i < frames; i++) begin
      r = $urandom_range(99);
      if (r < 2) begin
        t = t - 32'($urandom_range(0, 5000));
      end else if (r >= 4) begin
        t = t + 32'(FrameStep - 20 + $urandom_range(0, 40));
      end
      lvl = 24'(floor_lvl + $urandom_range(0, noise_max));
      if (i % period == 0 && $urandom_range(99) >= drop_pct) begin
        lvl = lvl + 24'(pulse_amp);
      end
      send_frame(t, lvl);
    end
  endtask

  task automatic play_noise(input int frames);
    for (int i = 0; i < frames; i++) begin
      send_frame($urandom, 24'($urandom_range(0, 24'hFF_FFFF)));
    end
  endtask

  task automatic pick_config(input int p);
    int kind;
    kind = (p == 0) ? 0 : $urandom_range(3);
    case (kind)
      0: write_config(MinBeatGapRst, PhaseWindowRst, ConfidenceStepRst,
                      PredictThresholdRst);
      1: write_config(16'($urandom_range(8000, 30000)), 16'($urandom_range(3000, 30000)),
                      16'($urandom_range(2000, 12000)), 17'($urandom_range(50000, 65536)));
      2: write_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 32768)), 17'($urandom_range(32768, 65536)));
      default: write_config($urandom_range(1) ? 16'hFFFF : 16'd0,
                            $urandom_range(1) ? 16'hFFFF : 16'd0,
                            $urandom_range(1) ? 16'd32768 : 16'd0,
                            $urandom_range(1) ? 17'd65536 : 17'd32768);
    endcase
  endtask

  initial begin
    int start, left;
    bit drained;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    // Random phases. Idling cycles through: none, sender idle 83%, receiver
    // stalling 83%, both at 9%. Each phase starts from an idle block with a
    // fresh register setting and drains once in its middle.
    for (int p = 0; p < PhaseCount; p++) begin
      idle_pct  = (p % 4 == 1) ? 83 : ((p % 4 == 3) ? 9 : 0);
      stall_pct = (p % 4 == 2) ? 83 : ((p % 4 == 3) ? 9 : 0);
      pick_config(p);
      start = chk.n_frames;
      drained = 1'b0;
      while (chk.n_frames - start < PhaseFrames) begin
        left = PhaseFrames - (chk.n_frames - start);
        if ($urandom_range(99) < 10) begin
          play_noise((left < 6) ? left : $urandom_range(3, 6));
        end else begin
          play_song((left < 15) ? left : $urandom_range(15, (left < 50) ? left : 50));
        end
        // With no idling on either side, stall the receiver long enough for
        // the block to fill and push back on the sender.
        if (p == 0 && !long_hold_req && hold_left == 0 && !drained) begin
          long_hold_req = 1'b1;
        end
        if (!drained && chk.n_frames - start >= PhaseFrames / 2) begin
          wait_idle();
          drained = 1'b1;
        end
      end
      wait_idle();
    end

    repeat (TailCycles) @(posedge clk);
    $display("Checked %0d results from %0d frames over %0d register settings:",
             chk.n_results, chk.n_frames, PhaseCount + 3);
    $display("  %0d beats flagged, %0d landed in phase, %0d predicted.",
             chk.n_hits, chk.n_in_phase, chk.n_forced);
    if (chk.n_errors == 0 && chk.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
